// ===== src/gmr_pkg.sv =====
// ----------------------------------------------------------------------------
// Guest memory package
// Operation codes and the command and status bundles that pass between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package gmr_pkg;

    localparam logic [2:0] FN_READ    = 3'd0;
    localparam logic [2:0] FN_WRITE   = 3'd1;
    localparam logic [2:0] FN_RESERVE = 3'd2;
    localparam logic [2:0] FN_STCOND  = 3'd3;
    localparam logic [2:0] FN_ZERO    = 3'd4;

    localparam logic [2:0] LG_WORD  = 3'd2;
    localparam logic [2:0] LG_DWORD = 3'd3;
    localparam logic [2:0] LG_QUAD  = 3'd4;

    typedef struct packed {
        logic latch;
        logic check;
        logic clr;
        logic rd;
        logic merge;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic skip;
        logic last_word;
        logic clr_last;
    } t_stat;

endpackage

// ===== src/gmr_ctrl.sv =====
// ----------------------------------------------------------------------------
// Guest memory controller
// Sequences the clearing pass, the window check and the per-word
// read-modify-write steps of one operation.
// ----------------------------------------------------------------------------
module gmr_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  gmr_pkg::t_stat i_stat,
    output gmr_pkg::t_cmd  o_cmd,
    output logic          o_busy
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CLEAR = 3'd1;
    localparam logic [2:0] S_CHECK = 3'd2;
    localparam logic [2:0] S_READ  = 3'd3;
    localparam logic [2:0] S_MERGE = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr = 1'b1;
                if (i_stat.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.latch = 1'b1;
                    n_state     = S_CHECK;
                end
            end
            S_CHECK: begin
                o_cmd.check = 1'b1;
                n_state     = i_stat.skip ? S_DONE : S_READ;
            end
            S_READ: begin
                o_cmd.rd = 1'b1;
                n_state  = S_MERGE;
            end
            S_MERGE: begin
                o_cmd.merge = 1'b1;
                n_state     = i_stat.last_word ? S_DONE : S_READ;
            end
            S_DONE: begin
                o_cmd.finish = 1'b1;
                n_state      = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

// ===== src/gmr_dp.sv =====
// ----------------------------------------------------------------------------
// Guest memory datapath
// Word-wide backing store, window check, byte lane merge, read data
// assembly and the generation counter.
// ----------------------------------------------------------------------------
module gmr_dp #(
    parameter int MEM_BYTES = 65536
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  gmr_pkg::t_cmd  i_cmd,
    output gmr_pkg::t_stat o_stat,
    input  logic [31:0]    i_base,
    input  logic [2:0]     i_func,
    input  logic [31:0]    i_address,
    input  logic [2:0]     i_lg,
    input  logic           i_be,
    input  logic [63:0]    i_wh,
    input  logic [63:0]    i_wl,
    input  logic [63:0]    i_tok,
    output logic           o_done,
    output logic [63:0]    o_rh,
    output logic [63:0]    o_rl,
    output logic           o_fault,
    output logic           o_stored,
    output logic [63:0]    o_gen
);

    localparam int AW    = $clog2(MEM_BYTES);
    localparam int WORDS = MEM_BYTES / 8;
    localparam int WL    = AW - 3;

    logic [63:0] mem [WORDS];

    logic [2:0]  r_func;
    logic [31:0] r_addr;
    logic [2:0]  r_lg;
    logic        r_be;
    logic [63:0] r_wh;
    logic [63:0] r_wl;
    logic [63:0] r_tok;
    logic [63:0] r_gen;
    logic [WL-1:0] r_wptr;
    logic signed [8:0] r_rel;
    logic [4:0]  r_left;
    logic        r_fault;
    logic        r_skip;
    logic [63:0] r_rdata;
    logic [7:0]  r_rbuf [16];
    logic        r_done;
    logic [63:0] r_rh;
    logic [63:0] r_rl;
    logic        r_res_fault;
    logic        r_res_stored;
    logic [63:0] r_res_gen;

    logic [7:0]  nbytes;
    logic [31:0] eff;
    logic        lo_ok;
    logic        hi_ok;
    logic        size_ok;
    logic        sc_miss;
    logic        fault_c;
    logic        skip_c;
    logic        wr_op;
    logic        rd_op;
    logic        zero_op;
    logic        be_eff;
    logic [31:0] diff;
    logic [AW-1:0] off;
    logic [7:0]  left_sum;
    logic [63:0] merged;
    logic [7:0]  inr;
    logic [3:0]  jj [8];
    logic        mem_we;
    logic [63:0] mem_wd;
    logic [63:0] gen_inc;
    logic [63:0] gen_next;
    logic [63:0] be_word;
    logic [63:0] le_word;
    logic [3:0]  be_pad;

    // Decode of the latched operation.
    always_comb begin
        nbytes  = 8'd1 << r_lg;
        zero_op = (r_func == gmr_pkg::FN_ZERO);
        eff     = zero_op ? (r_addr & ~{24'd0, nbytes - 8'd1}) : r_addr;
        lo_ok   = (eff >= i_base);
        hi_ok   = (({2'b0, eff} + {26'd0, nbytes}) <= ({2'b0, i_base} + 34'(MEM_BYTES)));
        unique case (r_func)
            gmr_pkg::FN_READ, gmr_pkg::FN_WRITE: size_ok = (r_lg <= gmr_pkg::LG_QUAD);
            gmr_pkg::FN_RESERVE, gmr_pkg::FN_STCOND:
                size_ok = (r_lg == gmr_pkg::LG_WORD) || (r_lg == gmr_pkg::LG_DWORD);
            gmr_pkg::FN_ZERO: size_ok = 1'b1;
            default: size_ok = 1'b0;
        endcase
        sc_miss = (r_func == gmr_pkg::FN_STCOND) && size_ok && (r_tok != r_gen);
        fault_c = !size_ok || (!sc_miss && !(lo_ok && hi_ok));
        skip_c  = fault_c || sc_miss;
        wr_op   = (r_func == gmr_pkg::FN_WRITE) || (r_func == gmr_pkg::FN_STCOND) || zero_op;
        rd_op   = (r_func == gmr_pkg::FN_READ) || (r_func == gmr_pkg::FN_RESERVE);
        be_eff  = r_be || (r_func == gmr_pkg::FN_RESERVE) || (r_func == gmr_pkg::FN_STCOND);
        diff    = eff - i_base;
        off     = diff[AW-1:0];
        left_sum = {5'd0, off[2:0]} + nbytes - 8'd1;
    end

    assign o_stat.skip      = skip_c;
    assign o_stat.last_word = (r_left == 5'd0);
    assign o_stat.clr_last  = (r_wptr == WL'(WORDS - 1));

    // Byte lane merge: lane k of the current word holds access byte r_rel + k.
    always_comb begin
        logic signed [8:0] j;
        logic [7:0] wb;
        logic [3:0] d;
        for (int k = 0; k < 8; k++) begin
            j      = r_rel + 9'(k);
            inr[k] = !j[8] && (j[7:0] < nbytes);
            jj[k]  = j[3:0];
            d      = nbytes[3:0] - 4'd1 - jj[k];
            if (zero_op) begin
                wb = 8'd0;
            end else if (r_lg == gmr_pkg::LG_QUAD) begin
                wb = 8'({r_wh, r_wl} >> (7'd120 - {jj[k], 3'b000}));
            end else if (be_eff) begin
                wb = 8'(r_wl >> {d[2:0], 3'b000});
            end else begin
                wb = 8'(r_wl >> {jj[k][2:0], 3'b000});
            end
            merged[8*k +: 8] = (inr[k] && wr_op) ? wb : r_rdata[8*k +: 8];
        end
    end

    assign mem_we = i_cmd.clr || (i_cmd.merge && wr_op);
    assign mem_wd = i_cmd.clr ? 64'd0 : merged;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[r_wptr] <= mem_wd;
        end
        if (i_cmd.rd) begin
            r_rdata <= mem[r_wptr];
        end
    end

    // Result assembly and generation update.
    always_comb begin
        gen_inc  = r_gen + 64'd1;
        gen_next = (gen_inc == 64'd0) ? 64'd1 : gen_inc;
        be_pad   = 4'd8 - nbytes[3:0];
        be_word  = {r_rbuf[0], r_rbuf[1], r_rbuf[2], r_rbuf[3],
                    r_rbuf[4], r_rbuf[5], r_rbuf[6], r_rbuf[7]} >> {be_pad[2:0], 3'b000};
        le_word  = {r_rbuf[7], r_rbuf[6], r_rbuf[5], r_rbuf[4],
                    r_rbuf[3], r_rbuf[2], r_rbuf[1], r_rbuf[0]};
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_func <= i_func;
            r_addr <= i_address;
            r_lg   <= i_lg;
            r_be   <= i_be;
            r_wh   <= i_wh;
            r_wl   <= i_wl;
            r_tok  <= i_tok;
        end
        if (i_cmd.check) begin
            r_rel   <= 9'sd0 - $signed({6'd0, off[2:0]});
            r_left  <= left_sum[7:3];
            r_fault <= fault_c;
            r_skip  <= skip_c;
            for (int i = 0; i < 16; i++) begin
                r_rbuf[i] <= 8'd0;
            end
        end
        if (i_cmd.merge) begin
            r_rel  <= r_rel + 9'sd8;
            r_left <= r_left - 5'd1;
            for (int k = 0; k < 8; k++) begin
                if (inr[k]) begin
                    r_rbuf[jj[k]] <= r_rdata[8*k +: 8];
                end
            end
        end
        if (i_cmd.finish) begin
            r_res_fault  <= r_fault;
            r_res_stored <= (r_func == gmr_pkg::FN_STCOND) && !r_skip;
            r_res_gen    <= (!r_skip && wr_op) ? gen_next : r_gen;
            if (r_skip || !rd_op) begin
                r_rh <= 64'd0;
                r_rl <= 64'd0;
            end else if (r_lg == gmr_pkg::LG_QUAD) begin
                r_rh <= {r_rbuf[0], r_rbuf[1], r_rbuf[2], r_rbuf[3],
                         r_rbuf[4], r_rbuf[5], r_rbuf[6], r_rbuf[7]};
                r_rl <= {r_rbuf[8], r_rbuf[9], r_rbuf[10], r_rbuf[11],
                         r_rbuf[12], r_rbuf[13], r_rbuf[14], r_rbuf[15]};
            end else begin
                r_rh <= 64'd0;
                r_rl <= be_eff ? be_word : le_word;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gen  <= 64'd0;
            r_wptr <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= i_cmd.finish;
            if (i_cmd.finish && !r_skip && wr_op) begin
                r_gen <= gen_next;
            end
            if (i_cmd.check) begin
                r_wptr <= off[AW-1:3];
            end else if (i_cmd.clr || i_cmd.merge) begin
                r_wptr <= r_wptr + 1'b1;
            end
        end
    end

    assign o_done   = r_done;
    assign o_rh     = r_rh;
    assign o_rl     = r_rl;
    assign o_fault  = r_res_fault;
    assign o_stored = r_res_stored;
    assign o_gen    = r_res_gen;

endmodule

// ===== src/guest_memory_with_reservation.sv =====
// ----------------------------------------------------------------------------
// Guest memory with reservation
// Byte-addressed guest memory window with load-reserve / store-conditional.
// ----------------------------------------------------------------------------
// Each access is window-checked, then read and merged one 8-byte word at a
// time, then finished; a faulting or mismatched access skips the words.
// A 128-byte zero block is written a word at a time by the single memory port.
// One transfer at a time; busy is high from accept until the result strobe.
// After reset the store is cleared one word at a time with busy high.
// The receiver cannot stall; each result shows for one cycle on o_done.
module guest_memory_with_reservation #(
    parameter int MEM_BYTES = 65536
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Command channel
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  i_func,
    input  logic [31:0] i_address,
    input  logic [2:0]  i_access_size_log2,
    input  logic        i_big_endian,
    input  logic [63:0] i_write_high,
    input  logic [63:0] i_write_low,
    input  logic [63:0] i_reservation_token,
    // Result channel
    output logic        o_done,
    output logic [63:0] o_read_high,
    output logic [63:0] o_read_low,
    output logic        o_fault,
    output logic        o_stored,
    output logic [63:0] o_generation_out,
    // Configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic        paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    gmr_pkg::t_cmd  cmd;
    gmr_pkg::t_stat stat;

    // The base address register is the only configuration register, at
    // byte address zero. Writes elsewhere are ignored and read as zero.
    logic [31:0] r_base;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base <= 32'd0;
        end else if (psel && penable && pwrite && !paddr) begin
            r_base <= pwdata;
        end
    end

    assign pready = 1'b1;
    assign prdata = paddr ? 32'd0 : r_base;

    // The controller steps through the window check and one read plus one
    // merge per touched word, written back for writing operations; the datapath owns the store.
    gmr_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    gmr_dp #(
        .MEM_BYTES (MEM_BYTES)
    ) u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (cmd),
        .o_stat    (stat),
        .i_base    (r_base),
        .i_func    (i_func),
        .i_address (i_address),
        .i_lg      (i_access_size_log2),
        .i_be      (i_big_endian),
        .i_wh      (i_write_high),
        .i_wl      (i_write_low),
        .i_tok     (i_reservation_token),
        .o_done    (o_done),
        .o_rh      (o_read_high),
        .o_rl      (o_read_low),
        .o_fault   (o_fault),
        .o_stored  (o_stored),
        .o_gen     (o_generation_out)
    );

endmodule

// ===== src/gmr_checker.sv =====
// ----------------------------------------------------------------------------
// Guest memory checker
// Port-level properties of the command and result channels.
// ----------------------------------------------------------------------------
module gmr_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic        o_done,
    input logic [63:0] o_read_high,
    input logic [63:0] o_read_low,
    input logic        o_fault,
    input logic        o_stored,
    input logic [63:0] o_generation_out
);

    // An accepted transfer keeps the block busy in the next cycle.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy) else $error("accept did not raise busy");

    // A result is shown for exactly one cycle.
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done) else $error("result strobe longer than one cycle");

    // The block is idle again while its result is shown.
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy) else $error("busy during result");

    // A faulting access returns no data and never stores.
    a_fault_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_fault) |-> (!o_stored && o_read_low == 64'd0 && o_read_high == 64'd0))
        else $error("faulting access returned data or stored");

    // A successful store-conditional leaves a nonzero generation.
    a_stored_gen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_stored) |-> (o_generation_out != 64'd0))
        else $error("generation zero after store");

endmodule

bind guest_memory_with_reservation gmr_checker u_gmr_checker (.*);

// ===== test/tb_top.sv =====
// ----------------------------------------------------------------------------
// Guest memory with reservation testbench
// Drives a directed table of operations and then a long stream of random
// operations through several base settings. A behavioral copy of the window
// predicts every result, and each strobed result is compared with it.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int MEM_BYTES = 65536;
    localparam int MAX_CYCLES = 3000000;

    // Function codes outside the package set.
    localparam logic [2:0] FN_BAD     = 3'd5;
    localparam logic [2:0] FN_BAD_TOP = 3'd7;

    typedef struct {
        logic [2:0]  func;
        logic [31:0] addr;
        logic [2:0]  lg;
        logic        be;
        logic [63:0] wh;
        logic [63:0] wl;
        logic [63:0] tok;
    } t_op;

    typedef struct packed {
        logic [63:0] rh;
        logic [63:0] rl;
        logic        fault;
        logic        stored;
        logic [63:0] gen;
    } t_res;

    // A directed row: the operation, and a typed-in result where obvious.
    typedef struct {
        t_op  op;
        logic known;
        t_res res;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [2:0]  i_func = '0;
    logic [31:0] i_address = '0;
    logic [2:0]  i_access_size_log2 = '0;
    logic        i_big_endian = 1'b0;
    logic [63:0] i_write_high = '0;
    logic [63:0] i_write_low = '0;
    logic [63:0] i_reservation_token = '0;
    logic        o_done;
    logic [63:0] o_read_high;
    logic [63:0] o_read_low;
    logic        o_fault;
    logic        o_stored;
    logic [63:0] o_generation_out;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic        paddr = 1'b0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    guest_memory_with_reservation #(.MEM_BYTES(MEM_BYTES)) dut (.*);

    always #1 i_clk = ~i_clk;

    // Shadow state of the window.
    logic [7:0]  shadow_mem [MEM_BYTES];
    logic [63:0] shadow_gen;
    logic [31:0] shadow_base;

    t_res        pending_results [$];
    int          fail_count = 0;
    longint      cycle_count = 0;

    // True when [addr, addr+len) lies inside the window; the sum is taken
    // wide so that nothing wraps.
    function automatic bit fits(logic [31:0] addr, int len, output int offset);
        logic [33:0] lo, hi;
        lo = {2'b0, addr};
        hi = {2'b0, shadow_base} + MEM_BYTES;
        offset = int'(addr - shadow_base);
        return (addr >= shadow_base) && (lo + len <= hi);
    endfunction

    function automatic logic [63:0] fetch(int offset, int n, bit be);
        logic [63:0] v;
        v = '0;
        for (int i = 0; i < n; i++) begin
            if (be) v = (v << 8) | shadow_mem[(offset + i) % MEM_BYTES];
            else v |= 64'(shadow_mem[(offset + i) % MEM_BYTES]) << (8 * i);
        end
        return v;
    endfunction

    task automatic deposit(int offset, int n, bit be, logic [63:0] v);
        for (int i = 0; i < n; i++)
            shadow_mem[(offset + i) % MEM_BYTES] = v >> (be ? 8 * (n - 1 - i) : 8 * i);
    endtask

    task automatic advance_gen();
        shadow_gen++;
        if (shadow_gen == 0) shadow_gen = 1;
    endtask

    // Applies one operation to the shadow window and returns its result.
    task automatic apply_op(input t_op op, output t_res r);
        int n, offset;
        logic [31:0] aligned;
        r = '{default: '0};
        n = 1 << op.lg;
        case (op.func)
            gmr_pkg::FN_READ: begin
                if (op.lg > gmr_pkg::LG_QUAD || !fits(op.addr, n, offset)) r.fault = 1'b1;
                else if (op.lg == gmr_pkg::LG_QUAD) begin
                    r.rh = fetch(offset, 8, 1'b1);
                    r.rl = fetch(offset + 8, 8, 1'b1);
                end else r.rl = fetch(offset, n, op.be);
            end
            gmr_pkg::FN_WRITE: begin
                if (op.lg > gmr_pkg::LG_QUAD || !fits(op.addr, n, offset)) r.fault = 1'b1;
                else begin
                    if (op.lg == gmr_pkg::LG_QUAD) begin
                        deposit(offset, 8, 1'b1, op.wh);
                        deposit(offset + 8, 8, 1'b1, op.wl);
                    end else deposit(offset, n, op.be, op.wl);
                    advance_gen();
                end
            end
            gmr_pkg::FN_RESERVE: begin
                if ((op.lg != gmr_pkg::LG_WORD && op.lg != gmr_pkg::LG_DWORD)
                    || !fits(op.addr, n, offset))
                    r.fault = 1'b1;
                else r.rl = fetch(offset, n, 1'b1);
            end
            gmr_pkg::FN_STCOND: begin
                // A stale token is simply refused, with no window check.
                if (op.lg != gmr_pkg::LG_WORD && op.lg != gmr_pkg::LG_DWORD) r.fault = 1'b1;
                else if (op.tok == shadow_gen) begin
                    if (!fits(op.addr, n, offset)) r.fault = 1'b1;
                    else begin
                        deposit(offset, n, 1'b1, op.wl);
                        advance_gen();
                        r.stored = 1'b1;
                    end
                end
            end
            gmr_pkg::FN_ZERO: begin
                aligned = op.addr & ~32'(n - 1);
                if (!fits(aligned, n, offset)) r.fault = 1'b1;
                else begin
                    for (int i = 0; i < n; i++) shadow_mem[(offset + i) % MEM_BYTES] = 8'h00;
                    advance_gen();
                end
            end
            default: r.fault = 1'b1;
        endcase
        r.gen = shadow_gen;
    endtask

    // Result checker: each strobe is compared with the oldest expectation.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (i_rst_n && o_done) begin
            if (pending_results.size() == 0) begin
                $error("result with nothing expected");
                fail_count++;
            end else begin
                t_res e;
                e = pending_results.pop_front();
                if (o_read_high !== e.rh) begin
                    $error("read_high exp %h got %h", e.rh, o_read_high); fail_count++;
                end
                if (o_read_low !== e.rl) begin
                    $error("read_low exp %h got %h", e.rl, o_read_low); fail_count++;
                end
                if (o_fault !== e.fault) begin
                    $error("fault exp %b got %b", e.fault, o_fault); fail_count++;
                end
                if (o_stored !== e.stored) begin
                    $error("stored exp %b got %b", e.stored, o_stored); fail_count++;
                end
                if (o_generation_out !== e.gen) begin
                    $error("generation_out exp %h got %h", e.gen, o_generation_out);
                    fail_count++;
                end
            end
        end
    end

    // Timeout watchdog.
    always @(posedge i_clk) begin
        if (cycle_count > MAX_CYCLES) begin
            $display("tb_top NOT OK");
            $finish;
        end
    end

    // Writes the base register through a setup and an access cycle.
    task automatic write_base(logic [31:0] value);
        psel <= 1'b1; pwrite <= 1'b1; paddr <= 1'b0; pwdata <= value; penable <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        shadow_base = value;
    endtask

    task automatic wait_drained();
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    // Random idle gap: mostly none or short, sometimes long.
    task automatic idle_gap();
        int k;
        k = $urandom_range(0, 99);
        if (k < 50) return;
        repeat (k < 90 ? $urandom_range(1, 3) : $urandom_range(10, 60)) @(posedge i_clk);
    endtask

    // Hands one operation to the block. The expectation is computed at the
    // accepting edge so that it is in place before the result can strobe.
    // Start drops for the cycle after the accept, while the block is busy
    // anyway, so the next transfer can still follow without a gap.
    task automatic issue(t_op op, bit known, t_res typed);
        t_res r;
        i_func <= op.func; i_address <= op.addr; i_access_size_log2 <= op.lg;
        i_big_endian <= op.be; i_write_high <= op.wh; i_write_low <= op.wl;
        i_reservation_token <= op.tok;
        start <= 1'b1;
        do @(posedge i_clk); while (busy);
        apply_op(op, r);
        if (known && r != typed) begin
            $error("directed row disagrees with prediction");
            fail_count++;
        end
        pending_results.push_back(known ? typed : r);
        start <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [63:0] rnd64();
        return {$urandom(), $urandom()};
    endfunction

    // Builds a random operation, mostly well-formed and inside the window.
    function automatic t_op random_op();
        t_op op;
        int k;
        op.func = $urandom_range(0, 99) < 3 ? 3'($urandom_range(5, 7)) : 3'($urandom_range(0, 4));
        op.be = $urandom_range(0, 1);
        op.wh = rnd64();
        op.wl = rnd64();
        case (op.func)
            gmr_pkg::FN_READ, gmr_pkg::FN_WRITE:
                op.lg = $urandom_range(0, 99) < 8 ? 3'($urandom_range(5, 7))
                                                 : 3'($urandom_range(0, 4));
            gmr_pkg::FN_RESERVE, gmr_pkg::FN_STCOND:
                op.lg = $urandom_range(0, 99) < 8 ? 3'($urandom_range(0, 7))
                                                 : 3'($urandom_range(2, 3));
            default: op.lg = $urandom_range(0, 99) < 90 ? 3'($urandom_range(0, 4))
                                                       : 3'($urandom_range(5, 7));
        endcase
        k = $urandom_range(0, 99);
        // Cluster accesses in a small region so reads meet earlier writes.
        if (k < 70) op.addr = shadow_base + $urandom_range(0, 255);
        else if (k < 85) op.addr = shadow_base + MEM_BYTES - $urandom_range(1, 20);
        else if (k < 92) op.addr = shadow_base - $urandom_range(1, 20);
        else op.addr = $urandom();
        // A store-conditional usually carries the live token.
        op.tok = ($urandom_range(0, 99) < 70) ? shadow_gen
               : ($urandom_range(0, 1) ? shadow_gen - 1 : rnd64());
        return op;
    endfunction

    t_row rows [$];

    task automatic add_row(logic [2:0] f, logic [31:0] a, logic [2:0] lg, logic be,
                           logic [63:0] wh, logic [63:0] wl, logic [63:0] tok,
                           logic known, t_res r);
        t_row x;
        x.op = '{f, a, lg, be, wh, wl, tok};
        x.known = known;
        x.res = r;
        rows.push_back(x);
    endtask

    localparam logic [63:0] ONES = '1;
    localparam t_res NONE = '{default: '0};

    initial begin
        t_op op;
        for (int i = 0; i < MEM_BYTES; i++) shadow_mem[i] = 8'h00;
        shadow_gen = '0;
        shadow_base = '0;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed rows; typed results are those obvious from reset state.
        add_row(gmr_pkg::FN_READ, 32'h0, 3'd3, 1'b1, 0, 0, 0, 1, '{0, 0, 0, 0, 0});
        add_row(gmr_pkg::FN_READ, 32'h0, 3'd5, 1'b0, 0, 0, 0, 1, '{0, 0, 1, 0, 0});
        add_row(FN_BAD, 32'h0, 3'd0, 1'b0, 0, 0, 0, 1, '{0, 0, 1, 0, 0});
        add_row(FN_BAD_TOP, 32'h0, 3'd0, 1'b0, 0, 0, 0, 1, '{0, 0, 1, 0, 0});
        add_row(gmr_pkg::FN_READ, 32'hFFFF_FFFF, 3'd0, 1'b0, 0, 0, 0, 1, '{0, 0, 1, 0, 0});
        add_row(gmr_pkg::FN_RESERVE, 32'h0, 3'd1, 1'b0, 0, 0, 0, 1, '{0, 0, 1, 0, 0});
        add_row(gmr_pkg::FN_STCOND, 32'h0, 3'd2, 1'b0, 0, ONES, 64'd5, 1, '{0, 0, 0, 0, 0});
        add_row(gmr_pkg::FN_WRITE, 32'h10, 3'd3, 1'b1, 0, 64'h0102030405060708, 0, 0, NONE);
        add_row(gmr_pkg::FN_READ, 32'h10, 3'd3, 1'b0, 0, 0, 0, 0, NONE);
        add_row(gmr_pkg::FN_READ, 32'h11, 3'd1, 1'b1, 0, 0, 0, 0, NONE);
        add_row(gmr_pkg::FN_WRITE, 32'h20, 3'd4, 1'b0, ONES, 64'h0, 0, 0, NONE);
        add_row(gmr_pkg::FN_WRITE, 32'h30, 3'd4, 1'b1, 64'h8877665544332211, ONES, 0, 0,
                NONE);
        add_row(gmr_pkg::FN_READ, 32'h2C, 3'd4, 1'b0, 0, 0, 0, 0, NONE);
        add_row(gmr_pkg::FN_WRITE, 32'hFFF8 + 3, 3'd3, 1'b0, 0, ONES, 0, 0, NONE);
        add_row(gmr_pkg::FN_WRITE, 32'hFFFF, 3'd0, 1'b0, 0, ONES, 0, 0, NONE);
        add_row(gmr_pkg::FN_RESERVE, 32'h10, 3'd3, 1'b0, 0, 0, 0, 0, NONE);
        add_row(gmr_pkg::FN_STCOND, 32'h10, 3'd3, 1'b0, 0, 64'hDEADBEEF, 64'd6, 0, NONE);
        add_row(gmr_pkg::FN_STCOND, 32'hFFFE, 3'd2, 1'b0, 0, 64'h1, 64'd7, 0, NONE);
        add_row(gmr_pkg::FN_STCOND, 32'h40, 3'd2, 1'b0, 0, ONES, 64'd7, 0, NONE);
        add_row(gmr_pkg::FN_ZERO, 32'h3F, 3'd7, 1'b0, 0, 0, 0, 0, NONE);
        add_row(gmr_pkg::FN_ZERO, 32'hFFFF, 3'd7, 1'b0, 0, 0, 0, 0, NONE);
        add_row(gmr_pkg::FN_ZERO, 32'h1_0000, 3'd0, 1'b0, 0, 0, 0, 0, NONE);
        add_row(gmr_pkg::FN_READ, 32'h10, 3'd4, 1'b0, 0, 0, 0, 0, NONE);
        foreach (rows[i]) begin
            issue(rows[i].op, rows[i].known, rows[i].res);
            idle_gap();
        end

        // Random phases, each with its own base, the extremes among them.
        for (int phase = 0; phase < 6; phase++) begin
            logic [31:0] base;
            wait_drained();
            case (phase)
                0: base = 32'h0;
                1: base = 32'hFFFF_0000;
                2: base = 32'hFFFF_FFFF;
                3: base = 32'h8000_1234;
                default: base = $urandom();
            endcase
            write_base(base);
            for (int n = 0; n < 300; n++) begin
                op = random_op();
                issue(op, 1'b0, NONE);
                // Pause once per phase until every expected result has come.
                if (n == 150) begin
                    wait_drained();
                end
                if ($urandom_range(0, 19) != 0) idle_gap();
            end
        end

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule
